// File: src/pc_selection_chisq_core_defines.svh
// ----------------------------------------------------------------------------
// pc_selection_chisq_core_defines : assertion macros
// Shared assertion forms for the PC selection statistic core.
// ----------------------------------------------------------------------------
`ifndef PC_SELECTION_CHISQ_CORE_DEFINES_SVH
`define PC_SELECTION_CHISQ_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset
`define PCS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define PCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg : shared definitions
// Sizes, codes and controller/datapath interface types of the PC selection core.
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int MAX_PCS     = 16;

    localparam int ROW_W   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int PC_W    = (MAX_PCS > 1) ? $clog2(MAX_PCS) : 1;
    localparam int VADDR_W = $clog2(MAX_SAMPLES * MAX_PCS);

    // magnitude of N*vg - S*v1, split for the squaring steps
    localparam int M_W    = 45;
    localparam int M_LO_W = 22;
    localparam int M_HI_W = M_W - M_LO_W;
    localparam int PROD_W = 2 * M_HI_W;
    localparam int NUM_W  = 2 * M_W + 3;
    localparam int DEN_W  = 56;
    localparam int CNT_W  = $clog2(NUM_W);
    localparam int STAT_W = 48;

    localparam logic [STAT_W-1:0] STAT_MAX = '1;

    localparam logic [1:0] OP_VEC  = 2'd0;
    localparam logic [1:0] OP_EIG  = 2'd1;
    localparam logic [1:0] OP_GENO = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [1:0] GENO_MISSING = 2'd3;

    localparam logic CFG_SAMPLES = 1'b0;
    localparam logic CFG_PCS     = 1'b1;

    localparam logic [10:0] SAMPLES_RST = 11'd1024;
    localparam logic [4:0]  PCS_RST     = 5'd10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_DRAIN,
        ST_RES_D,
        ST_RES_M,
        ST_SQ,
        ST_DIV,
        ST_OUT,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic            tbl_wr_vec;
        logic            tbl_wr_eig;
        logic            sample_take;
        logic            rd_en;
        logic [PC_W-1:0] k;
        logic            pos_inc;
        logic            marker_clear;
        logic            res_load;
        logic            res_mag;
        logic            sq_en;
        logic [1:0]      sq_sel;
        logic            div_step;
        logic            out_load;
        logic            out_last;
    } cmd_t;

    typedef struct packed {
        logic            last_sample;
        logic            undef;
        logic            out_free;
        logic [PC_W-1:0] npc_last;
    } stat_t;

endpackage

// File: src/pc_selection_chisq_core.sv
// ----------------------------------------------------------------------------
// pc_selection_chisq_core : PC selection chi-square statistic
// Per-marker accumulation of genotype-weighted eigenvector sums and statistic.
// ----------------------------------------------------------------------------
// Usage:
//   Input words on s_*: s_tuser selects the operation (eigenvector write,
//   eigenvalue write or genotype). Load the tables first, then send one
//   genotype word per sample in sample order.
//   The time a genotype word takes is set by the single eigenvector memory
//   read port walked once per PC.
//   After the final sample of a marker one result word per PC leaves on m_*,
//   m_tlast marking the last PC. Most of the work for each PC is in the
//   bit-serial divider (one quotient bit per cycle over 93 bits); a PC whose
//   statistic is undefined skips the divider.
//   Results pass through an output register: the next PC is computed while
//   a word waits, and a stalled m_tready holds the loop before the next load.
//   Sums are cleared after the last result; input is then accepted again.
//   Reset (aresetn low, synchronous) clears the sums, counters and output
//   valid and sets sample_count to 1024 and pc_count to 10. Tables are not
//   cleared and must be written before use.
//   Configuration writes via cfg_* are taken whenever cfg_wr_en is high.
// ----------------------------------------------------------------------------
module pc_selection_chisq_core
    import pcs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: index 0 sample_count, index 1 pc_count
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [10:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // sample_index, pc_index, vector_entry, eigen_value, genotype
    input  logic [1:0]  s_tuser,   // operation
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // pc_number, statistic, zero pad
    output logic        m_tuser,   // undefined_flag
    output logic        m_tlast    // last
);

    cmd_t  cmd;
    stat_t sts;

    // sequence accumulation and the per-PC result loop
    pcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    // tables, sums, arithmetic and output register
    pcs_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// File: src/pcs_dp.sv
// ----------------------------------------------------------------------------
// pcs_dp : datapath
// Tables, per-PC sums, statistic arithmetic, serial divider and output register.
// ----------------------------------------------------------------------------
module pcs_dp
    import pcs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [63:0] s_tdata,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [10:0] cfg_wdata,
    input  cmd_t        cmd,
    output stat_t       sts,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast
);

    logic [9:0]  sidx;
    logic [3:0]  pidx;
    logic [15:0] vent;
    logic [31:0] evalue;
    logic [1:0]  geno;

    assign sidx   = s_tdata[9:0];
    assign pidx   = s_tdata[13:10];
    assign vent   = s_tdata[29:14];
    assign evalue = s_tdata[61:30];
    assign geno   = s_tdata[63:62];

    // configuration
    logic [10:0] smp_cnt_reg;
    logic [4:0]  pc_cnt_reg;
    int          smp_eff;
    int          pc_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smp_cnt_reg <= SAMPLES_RST;
            pc_cnt_reg  <= PCS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SAMPLES: smp_cnt_reg <= cfg_wdata;
                CFG_PCS:     pc_cnt_reg  <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (smp_cnt_reg == '0)                    smp_eff = 1;
        else if (int'(smp_cnt_reg) > MAX_SAMPLES) smp_eff = MAX_SAMPLES;
        else                                      smp_eff = int'(smp_cnt_reg);
        if (pc_cnt_reg == '0)                     pc_eff = 1;
        else if (int'(pc_cnt_reg) > MAX_PCS)      pc_eff = MAX_PCS;
        else                                      pc_eff = int'(pc_cnt_reg);
    end

    // eigenvector memory and eigenvalue table
    logic [15:0]        vmem [MAX_SAMPLES*MAX_PCS];
    logic [15:0]        vrd_reg;
    logic [31:0]        eig_mem [MAX_PCS];
    logic [ROW_W-1:0]   pos_reg;
    logic [VADDR_W-1:0] waddr;
    logic [VADDR_W-1:0] raddr;
    logic               vec_ok;
    logic               pc_ok;

    assign pc_ok  = int'(pidx) < MAX_PCS;
    assign vec_ok = (int'(sidx) < MAX_SAMPLES) && pc_ok;
    assign waddr  = VADDR_W'(int'(sidx) * MAX_PCS + int'(pidx));
    assign raddr  = VADDR_W'(int'(pos_reg) * MAX_PCS + int'(cmd.k));

    always_ff @(posedge aclk) begin
        if (cmd.tbl_wr_vec && vec_ok) begin
            vmem[waddr] <= vent;
        end
        if (cmd.rd_en) begin
            vrd_reg <= vmem[raddr];
        end
        if (cmd.tbl_wr_eig && pc_ok) begin
            eig_mem[PC_W'(pidx)] <= evalue;
        end
    end

    // per-sample accumulation, one PC per cycle behind the memory read
    logic            add_vld_reg;
    logic [PC_W-1:0] add_k_reg;
    logic [31:0]     ws_reg [MAX_PCS];
    logic [31:0]     ps_reg [MAX_PCS];
    logic [PC_W-1:0] sum_idx;
    logic [31:0]     ws_cur;
    logic [31:0]     ps_cur;
    logic [31:0]     v32;
    logic [1:0]      geno_reg;
    logic [10:0]     n_reg;
    logic [11:0]     s_reg;

    assign sum_idx = add_vld_reg ? add_k_reg : cmd.k;
    assign ws_cur  = ws_reg[sum_idx];
    assign ps_cur  = ps_reg[sum_idx];
    assign v32     = {{16{vrd_reg[15]}}, vrd_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            add_vld_reg <= 1'b0;
        end else begin
            add_vld_reg <= cmd.rd_en;
        end
        add_k_reg <= cmd.k;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.marker_clear) begin
            for (int i = 0; i < MAX_PCS; i++) begin
                ws_reg[i] <= '0;
                ps_reg[i] <= '0;
            end
        end else if (add_vld_reg) begin
            ps_reg[add_k_reg] <= ps_cur + v32;
            case (geno_reg)
                2'd1:    ws_reg[add_k_reg] <= ws_cur + v32;
                2'd2:    ws_reg[add_k_reg] <= ws_cur + {v32[30:0], 1'b0};
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.marker_clear) begin
            geno_reg <= '0;
            n_reg    <= '0;
            s_reg    <= '0;
            pos_reg  <= '0;
        end else begin
            if (cmd.sample_take) begin
                geno_reg <= geno;
                if (geno != GENO_MISSING) begin
                    n_reg <= n_reg + 11'd1;
                    s_reg <= s_reg + 12'(geno);
                end
            end
            if (cmd.pos_inc) begin
                pos_reg <= pos_reg + ROW_W'(1);
            end
        end
    end

    // statistic: products, magnitude and denominator
    logic [11:0]        two_n;
    logic signed [43:0] p1_reg;
    logic signed [44:0] p2_reg;
    logic [23:0]        den1_reg;
    logic [31:0]        e_reg;
    logic               undef_reg;
    logic [M_W-1:0]     m_reg;
    logic [DEN_W-1:0]   den_reg;
    logic signed [45:0] diff;

    assign two_n = {n_reg, 1'b0};
    assign diff  = 46'(p1_reg) - 46'(p2_reg);

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            p1_reg    <= $signed({1'b0, n_reg}) * $signed(ws_cur);
            p2_reg    <= $signed({1'b0, s_reg}) * $signed(ps_cur);
            den1_reg  <= 24'(s_reg) * 24'(two_n - s_reg);
            e_reg     <= eig_mem[cmd.k];
            undef_reg <= (s_reg == '0) || (s_reg >= two_n) || (eig_mem[cmd.k] == '0);
        end
        if (cmd.res_mag) begin
            m_reg   <= M_W'(diff[45] ? -diff : diff);
            den_reg <= DEN_W'(den1_reg) * DEN_W'(e_reg);
        end
    end

    // square in three partial products, then restoring division
    logic [M_LO_W-1:0] m_lo;
    logic [M_HI_W-1:0] m_hi;
    logic [PROD_W-1:0] prod;
    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  r_reg;
    logic [DEN_W:0]    r_sh;
    logic              ge;
    logic [STAT_W-1:0] q_reg;
    logic              sat_reg;

    assign m_lo = m_reg[M_LO_W-1:0];
    assign m_hi = m_reg[M_W-1:M_LO_W];
    assign r_sh = {r_reg, num_reg[NUM_W-1]};
    assign ge   = r_sh >= {1'b0, den_reg};

    always_comb begin
        case (cmd.sq_sel)
            2'd0:    prod = PROD_W'(m_lo) * PROD_W'(m_lo);
            2'd1:    prod = PROD_W'(m_hi) * PROD_W'(m_lo);
            default: prod = PROD_W'(m_hi) * PROD_W'(m_hi);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.sq_en) begin
            case (cmd.sq_sel)
                2'd0:    num_reg <= NUM_W'(prod);
                2'd1:    num_reg <= num_reg + (NUM_W'(prod) << (M_LO_W + 1));
                default: num_reg <= (num_reg + (NUM_W'(prod) << (2 * M_LO_W))) << 3;
            endcase
            r_reg   <= '0;
            q_reg   <= '0;
            sat_reg <= 1'b0;
        end else if (cmd.div_step) begin
            num_reg <= num_reg << 1;
            r_reg   <= ge ? DEN_W'(r_sh - {1'b0, den_reg}) : DEN_W'(r_sh);
            q_reg   <= {q_reg[STAT_W-2:0], ge};
            sat_reg <= sat_reg | q_reg[STAT_W-1];
        end
    end

    // output register
    logic              m_tvalid_reg;
    logic [PC_W-1:0]   pc_out_reg;
    logic [STAT_W-1:0] stat_out_reg;
    logic              flag_out_reg;
    logic              last_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            pc_out_reg   <= cmd.k;
            stat_out_reg <= undef_reg ? '0 : (sat_reg ? STAT_MAX : q_reg);
            flag_out_reg <= undef_reg;
            last_out_reg <= cmd.out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, stat_out_reg, 4'(pc_out_reg)};
    assign m_tuser  = flag_out_reg;
    assign m_tlast  = last_out_reg;

    assign sts.last_sample = (int'(pos_reg) + 1) >= smp_eff;
    assign sts.undef       = undef_reg;
    assign sts.out_free    = !m_tvalid_reg || m_tready;
    assign sts.npc_last    = PC_W'(pc_eff - 1);

endmodule

// File: src/pcs_ctrl.sv
// ----------------------------------------------------------------------------
// pcs_ctrl : controller
// Sequences table writes, sample accumulation and the per-PC statistic loop.
// ----------------------------------------------------------------------------
`include "pc_selection_chisq_core_defines.svh"

module pcs_ctrl
    import pcs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [1:0] s_tuser,
    input  stat_t      sts,
    output cmd_t       cmd
);

    state_t           state_reg, state_next;
    logic [PC_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             take;
    logic             k_last;

    assign take   = s_tvalid && (state_reg == ST_IDLE);
    assign k_last = k_reg == sts.npc_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                k_next = '0;
                if (take && s_tuser == OP_GENO) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                if (k_last) begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end else begin
                    k_next = k_reg + PC_W'(1);
                end
            end
            ST_DRAIN: begin
                state_next = sts.last_sample ? ST_RES_D : ST_IDLE;
            end
            ST_RES_D: begin
                state_next = ST_RES_M;
            end
            ST_RES_M: begin
                cnt_next   = '0;
                state_next = sts.undef ? ST_OUT : ST_SQ;
            end
            ST_SQ: begin
                if (cnt_reg == CNT_W'(2)) begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DIV: begin
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    state_next = ST_OUT;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    if (k_last) begin
                        state_next = ST_CLEAR;
                    end else begin
                        k_next     = k_reg + PC_W'(1);
                        state_next = ST_RES_D;
                    end
                end
            end
            ST_CLEAR: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd             = '0;
        cmd.k           = k_reg;
        cmd.sq_sel      = cnt_reg[1:0];
        cmd.tbl_wr_vec  = take && s_tuser == OP_VEC;
        cmd.tbl_wr_eig  = take && s_tuser == OP_EIG;
        cmd.sample_take = take && s_tuser == OP_GENO;
        case (state_reg)
            ST_ACC:   cmd.rd_en        = 1'b1;
            ST_DRAIN: cmd.pos_inc      = !sts.last_sample;
            ST_RES_D: cmd.res_load     = 1'b1;
            ST_RES_M: cmd.res_mag      = 1'b1;
            ST_SQ:    cmd.sq_en        = 1'b1;
            ST_DIV:   cmd.div_step     = 1'b1;
            ST_OUT: begin
                cmd.out_load = sts.out_free;
                cmd.out_last = sts.out_free && k_last;
            end
            ST_CLEAR: cmd.marker_clear = 1'b1;
            default: ;
        endcase
    end

    assign s_tready = state_reg == ST_IDLE;

    `PCS_ASSERT(a_take_idle, aclk, aresetn, cmd.sample_take |=> state_reg == ST_ACC, "sample not followed by accumulation")
    `PCS_ASSERT(a_load_free, aclk, aresetn, cmd.out_load |-> sts.out_free, "result loaded over a waiting word")
    `PCS_ASSERT(a_last_clear, aclk, aresetn, cmd.out_last |=> state_reg == ST_CLEAR, "final PC result without clearing")
    `PCS_ASSERT_ALWAYS(a_rd_busy, aclk, cmd.rd_en |-> !s_tready, "table read while accepting input")

endmodule
